// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational check sampled every cycle outside reset
`define SFR_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define SFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sfr_pkg.sv -----
`default_nettype none

package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPLACE = 8;
    localparam int JOB_BYTES   = 8;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_W       = 4;
    localparam int JOB_CNT_W   = $clog2(JOB_BYTES + 1);
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    // one classified input byte: the beats it causes
    typedef struct packed {
        logic [JOB_BYTES*BYTE_W-1:0] bytes;
        logic [JOB_CNT_W-1:0]        cnt;
        logic                        last;
        logic [COUNT_W-1:0]          count;
    } job_t;

endpackage

`default_nettype wire

// ----- sv/sfr_front.sv -----
`default_nettype none

module sfr_front #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    input  wire logic [sfr_pkg::BYTE_W-1:0]          in_byte,
    input  wire logic                                in_last,
    input  wire logic                                queue_full,
    output logic                                     push,
    output sfr_pkg::job_t                            job
);

    localparam int BW     = sfr_pkg::BYTE_W;
    localparam int LW     = sfr_pkg::LEN_W;
    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN*BW-1:0]  pat_reg;
    logic [LW-1:0]              plen_raw_reg;
    logic [MAX_REPLACE*BW-1:0]  rep_reg;
    logic [LW-1:0]              rlen_raw_reg;
    logic [BW-1:0]              window_reg [MAX_PATTERN];
    logic [BW-1:0]              window_next [MAX_PATTERN];
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          fill_next;
    logic [sfr_pkg::COUNT_W-1:0] count_reg;
    logic [sfr_pkg::COUNT_W-1:0] count_next;

    logic [BW-1:0]              wnew [MAX_PATTERN];
    logic [LW-1:0]              plen;
    logic [LW-1:0]              rlen;
    logic [LW-1:0]              fill_inc;
    logic                       full_win;
    logic                       hit;
    logic                       accept;
    logic [sfr_pkg::COUNT_W-1:0] count_step;

    assign accept = in_valid && !queue_full;

    always_comb
    begin
        if (plen_raw_reg == '0)
            plen = LW'(1);
        else if (plen_raw_reg > LW'(MAX_PATTERN))
            plen = LW'(MAX_PATTERN);
        else
            plen = plen_raw_reg;
        if (rlen_raw_reg > LW'(MAX_REPLACE))
            rlen = LW'(MAX_REPLACE);
        else
            rlen = rlen_raw_reg;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            wnew[i] = (fill_reg == FILL_W'(i)) ? in_byte : window_reg[i];
        end
        fill_inc = LW'(fill_reg) + LW'(1);
        full_win = (fill_inc == plen);
        hit = full_win;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((LW'(i) < plen) && (wnew[i] != pat_reg[i*BW +: BW]))
                hit = 1'b0;
        end
    end

    always_comb
    begin
        job        = '0;
        job.last   = in_last;
        count_step = count_reg;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            window_next[i] = wnew[i];
        end
        fill_next = FILL_W'(fill_inc);
        if (hit)
        begin
            job.bytes[MAX_REPLACE*BW-1:0] = rep_reg;
            job.cnt   = sfr_pkg::JOB_CNT_W'(rlen);
            fill_next = '0;
            if (count_reg != '1)
                count_step = count_reg + sfr_pkg::COUNT_W'(1);
        end
        else
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                job.bytes[i*BW +: BW] = wnew[i];
            end
            if (full_win)
            begin
                job.cnt = in_last ? sfr_pkg::JOB_CNT_W'(plen) : sfr_pkg::JOB_CNT_W'(1);
                for (int i = 0; i < MAX_PATTERN - 1; i++)
                begin
                    window_next[i] = wnew[i+1];
                end
                fill_next = FILL_W'(plen - LW'(1));
            end
            else
            begin
                job.cnt = in_last ? sfr_pkg::JOB_CNT_W'(fill_inc) : '0;
            end
        end
        job.count = count_step;
        count_next = count_step;
        if (in_last)
        begin
            fill_next  = '0;
            count_next = '0;
        end
        push = accept && ((job.cnt != '0) || in_last);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg      <= '0;
            plen_raw_reg <= LW'(1);
            rep_reg      <= '0;
            rlen_raw_reg <= '0;
            fill_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg  <= fill_next;
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                unique case (sfr_pkg::cfg_index_t'(cfg_index))
                    sfr_pkg::CFG_PATTERN_BYTES:
                        pat_reg <= cfg_data[MAX_PATTERN*BW-1:0];
                    sfr_pkg::CFG_PATTERN_LENGTH:
                    begin
                        plen_raw_reg <= cfg_data[LW-1:0];
                        fill_reg     <= '0;
                    end
                    sfr_pkg::CFG_REPLACEMENT_BYTES:
                        rep_reg <= cfg_data[MAX_REPLACE*BW-1:0];
                    sfr_pkg::CFG_REPLACEMENT_LENGTH:
                        rlen_raw_reg <= cfg_data[LW-1:0];
                    default:
                        rlen_raw_reg <= rlen_raw_reg;
                endcase
            end
        end
    end

`include "assert_macros.svh"

    `SFR_ASSERT_ALWAYS(a_fill_below_plen, LW'(fill_reg) < plen, "window fill reached pattern length")
    `SFR_ASSERT_NEXT(a_last_clears_fill, accept && in_last && !cfg_we, fill_reg == '0, "window not emptied after end of string")

endmodule

`default_nettype wire

// ----- sv/sfr_queue.sv -----
`default_nettype none

module sfr_queue #(
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sfr_pkg::job_t  push_job,
    input  wire logic           pop,
    output sfr_pkg::job_t       head,
    output logic                not_empty,
    output logic                full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_pkg::job_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

`include "assert_macros.svh"

    `SFR_ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full queue")
    `SFR_ASSERT_ALWAYS(a_no_underflow, !(pop && !not_empty), "pop from empty queue")

endmodule

`default_nettype wire

// ----- sv/sfr_back.sv -----
`default_nettype none

module sfr_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sfr_pkg::job_t                   head,
    input  wire logic                            head_valid,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [sfr_pkg::BYTE_W-1:0]           out_byte,
    output logic                                 byte_valid,
    output logic                                 run_last,
    output logic                                 string_end,
    output logic [sfr_pkg::COUNT_W-1:0]          match_count
);

    localparam int BW    = sfr_pkg::BYTE_W;
    localparam int CW    = sfr_pkg::JOB_CNT_W;
    localparam int IDX_W = (sfr_pkg::JOB_BYTES > 1) ? $clog2(sfr_pkg::JOB_BYTES) : 1;

    logic [IDX_W-1:0]            idx_reg;
    logic                        out_valid_reg;
    logic [BW-1:0]               out_byte_reg;
    logic                        byte_valid_reg;
    logic                        run_last_reg;
    logic                        string_end_reg;
    logic [sfr_pkg::COUNT_W-1:0] match_count_reg;

    logic                        load;
    logic                        bare;
    logic                        last_beat;

    assign bare      = (head.cnt == '0);
    assign last_beat = bare || (CW'(idx_reg) == head.cnt - CW'(1));
    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = load && last_beat;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= bare ? '0 : head.bytes[idx_reg*BW +: BW];
            byte_valid_reg  <= !bare;
            run_last_reg    <= last_beat;
            string_end_reg  <= last_beat && head.last;
            match_count_reg <= head.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= last_beat ? '0 : idx_reg + IDX_W'(1);
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign run_last    = run_last_reg;
    assign string_end  = string_end_reg;
    assign match_count = match_count_reg;

`include "assert_macros.svh"

    `SFR_ASSERT_IMPL(a_end_is_run_last, out_valid_reg && string_end_reg, run_last_reg, "string end without run end")
    `SFR_ASSERT_NEXT(a_mid_run_continues, pop == 1'b0 && load, idx_reg != '0, "beat index did not advance")

endmodule

`default_nettype wire

// ----- sv/stream_find_and_replace_unit.sv -----
// channel  | direction | handshake           | beat
// ---------+-----------+---------------------+-----------------------------------------
// input    | in        | in_valid / in_stall | in_byte, in_last
// output   | out       | out_valid/out_stall | out_byte, byte_valid, run_last,
//          |           |                     | string_end, match_count
// config   | in        | cfg_we              | cfg_index, cfg_data
// one input beat accepted per cycle while the job queue has room (four jobs)
// each input beat yields 0 to 8 output beats, sent one per cycle from the queue head while out_stall is low
// a replacement of n bytes is sent as n output beats; a beat passes the queue memory and the output register
// in_stall rises only when the queue is full; out_stall freezes a valid beat in the output register
// rst_n clears window fill, match count, queue and config to reset values
`default_nettype none

module stream_find_and_replace_unit #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [sfr_pkg::BYTE_W-1:0]      in_byte,
    input  wire logic                            in_last,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [sfr_pkg::BYTE_W-1:0]           out_byte,
    output logic                                 byte_valid,
    output logic                                 run_last,
    output logic                                 string_end,
    output logic [sfr_pkg::COUNT_W-1:0]          match_count
);

    sfr_pkg::job_t push_job;
    sfr_pkg::job_t head;
    logic          push;
    logic          pop;
    logic          not_empty;
    logic          full;

    assign in_stall = full;

    sfr_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .queue_full (full),
        .push       (push),
        .job        (push_job)
    );

    sfr_queue #(
        .DEPTH (sfr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    sfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (not_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .run_last    (run_last),
        .string_end  (string_end),
        .match_count (match_count)
    );

endmodule

`default_nettype wire
